[src/amcb_pkg.sv]
// shared types and constants for the alpha mask colour blend pipeline
// no dependencies
package amcb_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned NumChan = 3;
  localparam int unsigned ColW    = 32;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned WtW     = ChanW + 1;
  localparam int unsigned ProdW   = 2 * ChanW;
  localparam int unsigned SumW    = ProdW + 1;

  // channel lanes follow the byte order of a colour word
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  localparam logic [ColW-1:0]    NoColour = '1;
  localparam logic [WtW-1:0]     FullWt   = WtW'(256);
  localparam logic [CfgIdxW-1:0] RegFore  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegBack  = CfgIdxW'(1);

  typedef logic [ChanW-1:0] chan_t;
  typedef chan_t [NumChan-1:0] pix_t;

  typedef struct packed {
    chan_t w;
    pix_t  fc;
    pix_t  oc;
  } sel_t;

  typedef struct packed {
    logic [NumChan-1:0][ProdW-1:0] pa;
    logic [NumChan-1:0][ProdW-1:0] pb;
  } prod_t;

endpackage

[src/amcb_sel.sv]
// stage 1: colour registers, mode decode and operand selection
// depends on amcb_pkg
module amcb_sel import amcb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ColW-1:0]    cfg_wdata_i,
  input  logic               valid_i,
  output logic               stall_o,
  input  chan_t              alpha_i,
  input  pix_t               dest_i,
  output logic               valid_o,
  input  logic               stall_i,
  output sel_t               data_o
);

  typedef enum logic [1:0] {
    ModeFore,
    ModeBack,
    ModeMix
  } mode_e;

  logic [ColW-1:0] fore_q, back_q;
  logic            valid_q;
  sel_t            data_q, data_d;
  mode_e           mode;
  logic            fg_none, bg_none;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fore_q <= '0;
      back_q <= NoColour;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegFore: fore_q <= cfg_wdata_i;
        RegBack: back_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign fg_none = (fore_q == NoColour);
  assign bg_none = (back_q == NoColour);

  always_comb begin
    if (bg_none && !fg_none) begin
      mode = ModeFore;
    end else if (!bg_none && fg_none) begin
      mode = ModeBack;
    end else begin
      mode = ModeMix;
    end
  end

  always_comb begin
    data_d = '0;
    unique case (mode)
      ModeFore: begin
        data_d.w = alpha_i;
        for (int i = 0; i < NumChan; i++) begin
          data_d.fc[i] = fore_q[i*ChanW +: ChanW];
          data_d.oc[i] = dest_i[i];
        end
      end
      ModeBack: begin
        data_d.w = ~alpha_i;
        for (int i = 0; i < NumChan; i++) begin
          data_d.fc[i] = back_q[i*ChanW +: ChanW];
          data_d.oc[i] = dest_i[i];
        end
      end
      default: begin
        data_d.w = alpha_i;
        for (int i = 0; i < NumChan; i++) begin
          data_d.fc[i] = fore_q[i*ChanW +: ChanW];
          data_d.oc[i] = back_q[i*ChanW +: ChanW];
        end
      end
    endcase
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/amcb_mult.sv]
// stage 2: per-channel weighted products
// depends on amcb_pkg
module amcb_mult import amcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  sel_t  data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output prod_t data_o
);

  logic           valid_q;
  prod_t          data_q, data_d;
  logic [WtW-1:0] inv_wt;

  assign inv_wt = FullWt - {1'b0, data_i.w};

  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      data_d.pa[i] = ProdW'(data_i.fc[i]) * ProdW'(data_i.w);
      data_d.pb[i] = ProdW'(data_i.oc[i]) * ProdW'(inv_wt);
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/amcb_sum.sv]
// stage 3: product sum, scale down and output register
// depends on amcb_pkg
module amcb_sum import amcb_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  stall_o,
  input  prod_t data_i,
  output logic  valid_o,
  input  logic  stall_i,
  output pix_t  data_o
);

  logic            valid_q;
  pix_t            data_q, data_d;
  logic [SumW-1:0] sum;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NumChan; i++) begin
      sum       = SumW'(data_i.pa[i]) + SumW'(data_i.pb[i]);
      data_d[i] = sum[ProdW-1:ChanW];
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && !stall_o) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

[src/alpha_mask_colour_blend_top.sv]
// a pixel passes the registered select, multiply and sum stages in turn
// throughput: one pixel per cycle; each stage takes a new pixel when it is
// empty or its contents move on, so stalls lose nothing and bubbles close up
// reset: pipeline empty, foreground colour 0, background colour all ones (absent)
// top level of the alpha mask colour blend; depends on amcb_pkg, amcb_sel,
// amcb_mult and amcb_sum
module alpha_mask_colour_blend_top import amcb_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [ColW-1:0]    cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ChanW-1:0]   mask_alpha_i,
  input  logic [ChanW-1:0]   dest_blue_i,
  input  logic [ChanW-1:0]   dest_green_i,
  input  logic [ChanW-1:0]   dest_red_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ChanW-1:0]   out_blue_o,
  output logic [ChanW-1:0]   out_green_o,
  output logic [ChanW-1:0]   out_red_o
);

  pix_t  dest;
  pix_t  res;
  sel_t  sel_data;
  prod_t prod_data;
  logic  sel_valid, sel_stall;
  logic  mult_valid, mult_stall;

  always_comb begin
    dest[ChRed]   = dest_red_i;
    dest[ChGreen] = dest_green_i;
    dest[ChBlue]  = dest_blue_i;
  end

  amcb_sel u_sel (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .valid_i     (in_valid_i),
    .stall_o     (in_stall_o),
    .alpha_i     (mask_alpha_i),
    .dest_i      (dest),
    .valid_o     (sel_valid),
    .stall_i     (sel_stall),
    .data_o      (sel_data)
  );

  amcb_mult u_mult (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (sel_valid),
    .stall_o (sel_stall),
    .data_i  (sel_data),
    .valid_o (mult_valid),
    .stall_i (mult_stall),
    .data_o  (prod_data)
  );

  amcb_sum u_sum (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (mult_valid),
    .stall_o (mult_stall),
    .data_i  (prod_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (res)
  );

  assign out_red_o   = res[ChRed];
  assign out_green_o = res[ChGreen];
  assign out_blue_o  = res[ChBlue];

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (sel_valid && mult_valid && out_valid_o))
    else $error("input stalled while a pipeline stage is empty");

  a_sel_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sel_valid && !sel_stall) |=> mult_valid)
    else $error("pixel lost between select and multiply stages");

  a_mult_moves_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mult_valid && !mult_stall) |=> out_valid_o)
    else $error("pixel lost between multiply and sum stages");

  a_out_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(res)))
    else $error("stalled output pixel changed");
`endif

endmodule

[tb/sv/alpha_mask_colour_blend_top_tb.sv]
`timescale 1ns / 1ps
// testbench for alpha_mask_colour_blend_top: directed and random pixels under several colour
// settings, checked against a scoreboard that predicts each blended pixel; depends on amcb_pkg
module alpha_mask_colour_blend_top_tb import amcb_pkg::*; ();

  localparam logic [CfgIdxW-1:0] RegSpare   = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] RegTop     = '1;
  localparam int unsigned        IdlePct    = 26;
  localparam int unsigned        HoldCycles = 200;
  localparam int unsigned        QuietLimit = 2000;
  localparam int unsigned        PhaseItems = 240;
  localparam int unsigned        NumPhases  = 7;

  typedef enum {
    FgOnly, BgOnly, MixedSteady, MixedExtreme, BothAbsent, FgNearFull, BgZero
  } phase_e;

  class blend_checker;
    logic [ColW-1:0] fore_word;
    logic [ColW-1:0] back_word;
    pix_t            expected_pixels[$];
    int unsigned     mismatches;

    function new();
      fore_word  = '0;
      back_word  = NoColour;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [ColW-1:0] data);
      if (idx == RegFore) begin
        fore_word = data;
      end else if (idx == RegBack) begin
        back_word = data;
      end
    endfunction

    function chan_t blend_chan(chan_t colour, logic [WtW-1:0] wt, chan_t other);
      logic [SumW-1:0] acc;
      acc = colour * wt + other * (FullWt - wt);
      return acc[2*ChanW-1:ChanW];
    endfunction

    function void note_input(chan_t alpha, pix_t dest);
      pix_t fc;
      pix_t bc;
      pix_t res;
      bit   fore_on;
      bit   back_on;
      fc      = fore_word[NumChan*ChanW-1:0];
      bc      = back_word[NumChan*ChanW-1:0];
      fore_on = fore_word != NoColour;
      back_on = back_word != NoColour;
      for (int ch = 0; ch < NumChan; ch++) begin
        if (fore_on && !back_on) begin
          res[ch] = blend_chan(fc[ch], {1'b0, alpha}, dest[ch]);
        end else if (!fore_on && back_on) begin
          res[ch] = blend_chan(bc[ch], {1'b0, ~alpha}, dest[ch]);
        end else begin
          res[ch] = blend_chan(fc[ch], {1'b0, alpha}, bc[ch]);
        end
      end
      expected_pixels.push_back(res);
    endfunction

    function void check_output(pix_t got);
      string chan_name[NumChan];
      pix_t  want;
      chan_name[ChRed]   = "out_red";
      chan_name[ChGreen] = "out_green";
      chan_name[ChBlue]  = "out_blue";
      if (expected_pixels.size() == 0) begin
        $error("output transaction with no pixel pending");
        mismatches++;
        return;
      end
      want = expected_pixels.pop_front();
      for (int ch = 0; ch < NumChan; ch++) begin
        if (got[ch] !== want[ch]) begin
          $error("%s expected %0h actual %0h", chan_name[ch], want[ch], got[ch]);
          mismatches++;
        end
      end
    endfunction

    function int unsigned pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [ColW-1:0]    cfg_wdata_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [ChanW-1:0]   mask_alpha_i;
  logic [ChanW-1:0]   dest_blue_i;
  logic [ChanW-1:0]   dest_green_i;
  logic [ChanW-1:0]   dest_red_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [ChanW-1:0]   out_blue_o;
  logic [ChanW-1:0]   out_green_o;
  logic [ChanW-1:0]   out_red_o;

  blend_checker sb = new();
  bit           steady      = 1'b0;
  bit           hold_wanted = 1'b0;
  int unsigned  quiet_cycles = 0;

  alpha_mask_colour_blend_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .mask_alpha_i (mask_alpha_i),
    .dest_blue_i  (dest_blue_i),
    .dest_green_i (dest_green_i),
    .dest_red_i   (dest_red_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_blue_o   (out_blue_o),
    .out_green_o  (out_green_o),
    .out_red_o    (out_red_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        sb.note_input(mask_alpha_i, {dest_blue_i, dest_green_i, dest_red_i});
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_output({out_blue_o, out_green_o, out_red_o});
      end
    end
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int unsigned held;
    out_stall_i = 1'b0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        out_stall_i <= 1'b1;
        for (held = 0; held < HoldCycles; held++) @(posedge clk_i);
      end
      out_stall_i <= !steady && ($urandom_range(99) < IdlePct);
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ColW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.set_reg(idx, data);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_pixel(input chan_t alpha, input chan_t blue, input chan_t green,
                            input chan_t red);
    while (!steady && $urandom_range(99) < IdlePct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    mask_alpha_i <= alpha;
    dest_blue_i  <= blue;
    dest_green_i <= green;
    dest_red_i   <= red;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_corner_pixels();
    send_pixel(8'h00, 8'hff, 8'h80, 8'h01);
    send_pixel(8'hff, 8'h00, 8'h7f, 8'hfe);
    send_pixel(8'h80, 8'h55, 8'haa, 8'hff);
    send_pixel(8'h01, 8'hff, 8'h00, 8'h00);
  endtask

  function automatic logic [ColW-1:0] present_colour();
    logic [ColW-1:0] w;
    w = $urandom;
    if (w == NoColour) w[ColW-1] = 1'b0;
    return w;
  endfunction

  function automatic chan_t pick_alpha();
    int unsigned r;
    r = $urandom_range(9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return chan_t'($urandom);
  endfunction

  initial begin
    phase_e plan[NumPhases];
    phase_e kind;
    plan = '{FgOnly, BgOnly, MixedSteady, MixedExtreme, BothAbsent, FgNearFull, BgZero};
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    mask_alpha_i = '0;
    dest_blue_i  = '0;
    dest_green_i = '0;
    dest_red_i   = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset colours: black foreground, no background
    send_corner_pixels();
    drain();
    // top byte set but not all ones, so foreground stays present
    write_reg(RegFore, 32'h12ff_ffff);
    send_corner_pixels();
    drain();
    write_reg(RegFore, NoColour);
    write_reg(RegBack, 32'h00c0_b0a0);
    send_corner_pixels();
    drain();
    write_reg(RegFore, 32'h0000_ff00);
    write_reg(RegBack, 32'hab00_00ff);
    // writes to unmapped indexes must be ignored
    write_reg(RegSpare, NoColour);
    write_reg(RegTop, '0);
    send_corner_pixels();
    drain();
    write_reg(RegFore, NoColour);
    write_reg(RegBack, NoColour);
    send_corner_pixels();
    drain();

    for (int ph = 0; ph < NumPhases; ph++) begin
      kind = plan[ph];
      case (kind)
        FgOnly: begin
          write_reg(RegFore, present_colour());
          write_reg(RegBack, NoColour);
        end
        BgOnly: begin
          write_reg(RegFore, NoColour);
          write_reg(RegBack, present_colour());
        end
        MixedSteady: begin
          write_reg(RegFore, present_colour());
          write_reg(RegBack, present_colour());
        end
        MixedExtreme: begin
          write_reg(RegFore, '0);
          write_reg(RegBack, 32'h00ff_ffff);
        end
        BothAbsent: begin
          write_reg(RegFore, NoColour);
          write_reg(RegBack, NoColour);
        end
        FgNearFull: begin
          write_reg(RegFore, 32'hfeff_ffff);
          write_reg(RegBack, NoColour);
        end
        BgZero: begin
          write_reg(RegFore, NoColour);
          write_reg(RegBack, '0);
        end
        default: begin
          write_reg(RegFore, '0);
        end
      endcase
      steady      = (kind == MixedSteady);
      hold_wanted = (kind == BgOnly);
      for (int n = 0; n < PhaseItems; n++) begin
        send_pixel(pick_alpha(), chan_t'($urandom), chan_t'($urandom), chan_t'($urandom));
      end
      drain();
      steady = 1'b0;
    end

    repeat (8) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
